// File: rtl/brld_pkg.sv
// ----------------------------------------------------------------------------
// brld_pkg
// Shared types and constants for the byte run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package brld_pkg;

  // Decoder position within the compressed byte stream.
  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_REPEAT  = 2'd2
  } brld_mode_e;

  // Largest literal header; headers above EMPTY_HDR announce a repeat.
  localparam logic [7:0] LIT_MAX   = 8'd127;
  localparam logic [7:0] EMPTY_HDR = 8'd128;
  // Repeat count is the header minus this bias.
  localparam logic [7:0] REP_BIAS  = 8'd127;

  // Per-chunk decode state that does not depend on the counter width.
  typedef struct packed {
    brld_mode_e mode;
    logic [7:0] remaining;
    logic       failed;
  } brld_state_t;

  // One result item plus its valid flag.
  typedef struct packed {
    logic       valid;
    logic [7:0] value;
    logic [7:0] length;
    logic       overflow;
    logic       last;
  } brld_result_t;

endpackage

`default_nettype wire

// File: rtl/brld_step.sv
// ----------------------------------------------------------------------------
// brld_step
// Combinational decode of one payload byte against the current chunk state.
// ----------------------------------------------------------------------------
`default_nettype none

module brld_step #(
  parameter int COUNT_BITS = 24
) (
  input  brld_pkg::brld_state_t  state_i,
  input  logic [COUNT_BITS-1:0]  total_i,
  input  logic [COUNT_BITS-1:0]  limit_i,
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  output brld_pkg::brld_state_t  state_o,
  output logic [COUNT_BITS-1:0]  total_o,
  output brld_pkg::brld_result_t result_o
);

  logic                emit;
  logic [7:0]          run_len;
  logic [COUNT_BITS:0] sum;
  logic                fits;
  logic [7:0]          rem_dec;
  brld_pkg::brld_state_t st_run;
  logic [COUNT_BITS-1:0] tot_run;
  brld_pkg::brld_result_t res_run;

  assign emit    = !state_i.failed && (state_i.mode != brld_pkg::MODE_HEADER);
  assign run_len = (state_i.mode == brld_pkg::MODE_LITERAL) ? 8'd1 : state_i.remaining;
  assign sum     = {1'b0, total_i} + (COUNT_BITS+1)'(run_len);
  assign fits    = (sum <= {1'b0, limit_i});
  assign rem_dec = state_i.remaining - 8'd1;

  always_comb begin
    st_run  = state_i;
    tot_run = total_i;
    res_run = '0;
    if (emit) begin
      res_run.valid = 1'b1;
      if (fits) begin
        res_run.value  = byte_i;
        res_run.length = run_len;
        tot_run        = sum[COUNT_BITS-1:0];
        if (state_i.mode == brld_pkg::MODE_LITERAL) begin
          st_run.remaining = rem_dec;
          if (rem_dec == 8'd0) begin
            st_run.mode = brld_pkg::MODE_HEADER;
          end
        end else begin
          st_run.mode      = brld_pkg::MODE_HEADER;
          st_run.remaining = 8'd0;
        end
      end else begin
        // abandon the chunk
        res_run.overflow = 1'b1;
        st_run.failed    = 1'b1;
        st_run.mode      = brld_pkg::MODE_HEADER;
        st_run.remaining = 8'd0;
      end
    end else if (!state_i.failed) begin
      // header byte; empty headers change nothing
      if (byte_i != 8'd0 && byte_i <= brld_pkg::LIT_MAX) begin
        st_run.mode      = brld_pkg::MODE_LITERAL;
        st_run.remaining = byte_i;
      end else if (byte_i > brld_pkg::EMPTY_HDR) begin
        st_run.mode      = brld_pkg::MODE_REPEAT;
        st_run.remaining = byte_i - brld_pkg::REP_BIAS;
      end
    end
  end

  always_comb begin
    result_o = res_run;
    state_o  = st_run;
    total_o  = tot_run;
    if (last_i) begin
      if (!res_run.valid) begin
        result_o.valid    = 1'b1;
        result_o.overflow = st_run.failed;
      end
      result_o.last = 1'b1;
      state_o       = '0;
      total_o       = '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/byte_run_length_decoder.sv
// ----------------------------------------------------------------------------
// byte_run_length_decoder
// Run-length decoder for byte-oriented compressed chunks, one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one compressed payload
//   byte per transfer, with chunk_end_i marking the last byte of a chunk.
//   Output channel (out_valid_o / out_stall_i) carries decoded runs:
//   out_value_o repeated run_length_o times, plus overflow and is_last flags.
//   A byte yields zero or one result; the last byte of a chunk always yields
//   exactly one result with is_last_o set.
//   cfg_we_i / cfg_wdata_i write the per-chunk output limit; write only while
//   the block is idle.
// Timing:
//   One input register feeds the decode logic, which loads the result
//   register. A byte is transferred into the input register, and its result is
//   then offered from the result register. Throughput is one byte per cycle
//   while the receiver does not stall, set by the single decode pass.
// Reset and stall:
//   rst_ni clears all chunk state and sets the limit to 65536. While the
//   receiver stalls a waiting result, the input register still takes one
//   more byte, then in_stall_o holds the sender.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_run_length_decoder #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        chunk_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_value_o,
  output logic [7:0]  run_length_o,
  output logic        overflow_o,
  output logic        is_last_o
);

  localparam logic [31:0] LimitRst = 32'd65536;

  // limit register, low COUNT_BITS bits of the written value
  logic [COUNT_BITS-1:0] limit_q;
  logic [31:0]           wdata_ext;

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // chunk state
  brld_pkg::brld_state_t state_q, state_d;
  logic [COUNT_BITS-1:0] total_q, total_d;

  // result register
  logic                   out_valid_q;
  brld_pkg::brld_result_t res_d, res_q;

  logic s1_go, s1_fire, in_fire;

  assign wdata_ext = {8'd0, cfg_wdata_i};

  // Advance the input register whenever the result register is free.
  assign s1_go      = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_go;
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitRst[COUNT_BITS-1:0];
    end else if (cfg_we_i) begin
      limit_q <= wdata_ext[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= chunk_end_i;
    end
  end

  brld_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .state_i  (state_q),
    .total_i  (total_q),
    .limit_i  (limit_q),
    .byte_i   (s1_byte_q),
    .last_i   (s1_last_q),
    .state_o  (state_d),
    .total_o  (total_d),
    .result_o (res_d)
  );

  // Commit the decode step only when its byte leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      total_q <= '0;
    end else if (s1_fire) begin
      state_q <= state_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= s1_fire && res_d.valid;
    end
  end

  // Hold the payload while stalled; load only on a new result.
  always_ff @(posedge clk_i) begin
    if (s1_fire && res_d.valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = res_q.value;
  assign run_length_o = res_q.length;
  assign overflow_o   = res_q.overflow;
  assign is_last_o    = res_q.last;

  a_ovf_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> run_length_o == 8'd0 && out_value_o == 8'd0)
    else $error("overflow result carries a run");

  a_zero_len_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_length_o == 8'd0 |-> overflow_o || is_last_o)
    else $error("empty run without overflow or chunk end");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> run_length_o <= 8'd128)
    else $error("run length out of range");

  a_failed_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.failed |-> state_q.mode == brld_pkg::MODE_HEADER && state_q.remaining == 8'd0)
    else $error("abandoned chunk still decoding");

  a_chunk_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> total_q == '0 && !state_q.failed &&
      state_q.mode == brld_pkg::MODE_HEADER)
    else $error("chunk state not cleared at chunk end");

  a_total_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_last_q && !cfg_we_i |=> total_q <= limit_q)
    else $error("running total beyond limit");

endmodule

`default_nettype wire
